>>> rtl/bmfs_pkg.sv
// Package for the forward bracket matcher: sizes, character codes, bracket kinds,
// status codes and the stack command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmfs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int OFFSET_BITS = 24;
    localparam int CHAR_BITS   = 21;
    localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

    typedef logic [CHAR_BITS-1:0]   char_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam char_t CH_BACKSLASH = CHAR_BITS'(8'h5C);
    localparam char_t CH_DQUOTE    = CHAR_BITS'(8'h22);
    localparam char_t CH_SQUOTE    = CHAR_BITS'(8'h27);
    localparam char_t CH_LBRACE    = CHAR_BITS'(8'h7B);
    localparam char_t CH_LPAREN    = CHAR_BITS'(8'h28);
    localparam char_t CH_LSQUARE   = CHAR_BITS'(8'h5B);
    localparam char_t CH_RBRACE    = CHAR_BITS'(8'h7D);
    localparam char_t CH_RPAREN    = CHAR_BITS'(8'h29);
    localparam char_t CH_RSQUARE   = CHAR_BITS'(8'h5D);

    typedef enum logic [1:0] {
        KIND_BRACE  = 2'd0,
        KIND_PAREN  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_WRONG    = 2'd1,
        STATUS_END      = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        kind_t kind;
    } stack_cmd_t;

    function automatic kind_t opener_kind(input char_t c);
        kind_t k;
        k = KIND_NONE;
        if (c == CH_LBRACE) k = KIND_BRACE;
        else if (c == CH_LPAREN) k = KIND_PAREN;
        else if (c == CH_LSQUARE) k = KIND_SQUARE;
        return k;
    endfunction

    function automatic kind_t closer_kind(input char_t c);
        kind_t k;
        k = KIND_NONE;
        if (c == CH_RBRACE) k = KIND_BRACE;
        else if (c == CH_RPAREN) k = KIND_PAREN;
        else if (c == CH_RSQUARE) k = KIND_SQUARE;
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bmfs_if.sv
// Valid/ready channel interfaces for the bracket matcher: text in, result out.
// Depends on bmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmfs_in_if
    import bmfs_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t character;
    logic  first;
    logic  last;

    modport source (output valid, output character, output first, output last, input ready);
    modport sink   (input valid, input character, input first, input last, output ready);
endinterface

interface bmfs_out_if
    import bmfs_pkg::*;
;
    logic    valid;
    logic    ready;
    status_t status;
    offset_t match_offset;

    modport source (output valid, output status, output match_offset, input ready);
    modport sink   (input valid, input status, input match_offset, output ready);
endinterface

`default_nettype wire

>>> rtl/bmfs_stack.sv
// Shift-register stack of open bracket kinds; entry 0 is the top.
// Depends on bmfs_pkg. Depth tracking lives with the caller.
`timescale 1ns / 1ps
`default_nettype none

module bmfs_stack
    import bmfs_pkg::*;
(
    input  wire logic       clk,
    input  wire stack_cmd_t cmd,
    output kind_t           top
);

    kind_t entry_reg  [STACK_DEPTH];
    kind_t entry_next [STACK_DEPTH];

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            // shift down, new kind lands on top
            entry_next[0] = cmd.kind;
            for (int i = 1; i < STACK_DEPTH; i++)
            begin
                entry_next[i] = entry_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                entry_next[i] = entry_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign top = entry_reg[0];

endmodule

`default_nettype wire

>>> rtl/bracket_match_forward_scan.sv
// Forward bracket matcher: one text character per transfer in, at most one result
// transfer out per search. Each character is taken into an input register; once
// the output register is free or moving, a single update of scan mode, escape
// flag, stack and offset decides the result, which waits in an output register.
// The block takes one character per cycle while the result side is not stalled.
// A transfer with first set starts a search (and abandons any running one);
// characters with first clear while idle are dropped. The result gives status
// matched with the offset from the start bracket, wrong closer (also a closer on
// an empty stack), end of text, or stack overflow beyond 64 open brackets;
// match_offset is zero unless matched and saturates at its all-ones value.
// The stack is a shift register needing no clearing pass after reset.
// Depends on bmfs_pkg, bmfs_if and bmfs_stack.
`timescale 1ns / 1ps
`default_nettype none

module bracket_match_forward_scan
    import bmfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bmfs_in_if.sink   text,
    bmfs_out_if.source result
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_STRING = 2'd2
    } mode_t;

    // input register
    logic    in_valid_reg;
    char_t   char_reg;
    logic    first_reg;
    logic    last_reg;

    // scan state
    mode_t   mode_reg,      mode_next;
    logic    quote_dbl_reg, quote_dbl_next;
    logic    esc_reg,       esc_next;
    count_t  count_reg,     count_next;
    offset_t offset_reg,    offset_next;

    // output register
    logic    out_valid_reg;
    status_t status_reg,    status_next;
    offset_t match_reg,     match_next;
    logic    done;

    logic       active;
    logic       process;
    stack_cmd_t stack_cmd;
    kind_t      stack_top;

    // Process the held character only when the output register is free or moving.
    assign process    = in_valid_reg && (!out_valid_reg || result.ready);
    assign text.ready = !in_valid_reg || process;
    assign active     = first_reg || (mode_reg != MODE_IDLE);

    always_comb
    begin
        kind_t ok;
        kind_t ck;
        ok = opener_kind(char_reg);
        ck = closer_kind(char_reg);

        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        esc_next       = esc_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        done           = 1'b0;
        status_next    = STATUS_MATCH;
        match_next     = '0;
        stack_cmd      = '{push: 1'b0, pop: 1'b0, kind: ok};

        // A start bracket clears the search; otherwise advance the offset.
        if (first_reg)
        begin
            mode_next      = MODE_NORMAL;
            quote_dbl_next = 1'b0;
            esc_next       = 1'b0;
            count_next     = '0;
            offset_next    = '0;
        end
        else if (offset_reg != OFFSET_MAX)
        begin
            offset_next = offset_reg + OFFSET_BITS'(1);
        end

        if (esc_next)
        begin
            // skip the escaped character
            esc_next = 1'b0;
        end
        else if (mode_next == MODE_STRING)
        begin
            if (char_reg == CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if ((quote_dbl_next && char_reg == CH_DQUOTE) ||
                     (!quote_dbl_next && char_reg == CH_SQUOTE))
            begin
                mode_next = MODE_NORMAL;
            end
        end
        else
        begin
            if (char_reg == CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (char_reg == CH_DQUOTE || char_reg == CH_SQUOTE)
            begin
                mode_next      = MODE_STRING;
                quote_dbl_next = (char_reg == CH_DQUOTE);
            end
            else
            begin
                if (ok != KIND_NONE)
                begin
                    if (count_next >= COUNT_BITS'(STACK_DEPTH))
                    begin
                        done        = 1'b1;
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        stack_cmd.push = 1'b1;
                        count_next     = count_next + COUNT_BITS'(1);
                    end
                end
                else if (ck != KIND_NONE)
                begin
                    if (count_next == '0 || stack_top != ck)
                    begin
                        done        = 1'b1;
                        status_next = STATUS_WRONG;
                    end
                    else
                    begin
                        stack_cmd.pop = 1'b1;
                        count_next    = count_next - COUNT_BITS'(1);
                    end
                end
                if (!done && count_next == '0)
                begin
                    done        = 1'b1;
                    status_next = STATUS_MATCH;
                    match_next  = offset_next;
                end
            end
        end

        if (!done && last_reg)
        begin
            done        = 1'b1;
            status_next = STATUS_END;
        end

        if (done)
        begin
            mode_next = MODE_IDLE;
            esc_next  = 1'b0;
        end

        // Hold the stack unless this character really updates state.
        if (!(process && active))
        begin
            stack_cmd.push = 1'b0;
            stack_cmd.pop  = 1'b0;
        end
    end

    bmfs_stack u_stack (
        .clk (clk),
        .cmd (stack_cmd),
        .top (stack_top)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= MODE_IDLE;
            quote_dbl_reg <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // input register: load on transfer, drop once processed
            if (text.valid && text.ready)
            begin
                in_valid_reg <= 1'b1;
                char_reg     <= text.character;
                first_reg    <= text.first;
                last_reg     <= text.last;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process)
            begin
                out_valid_reg <= active && done;
                if (active)
                begin
                    mode_reg      <= mode_next;
                    quote_dbl_reg <= quote_dbl_next;
                    esc_reg       <= esc_next;
                    count_reg     <= count_next;
                    offset_reg    <= offset_next;
                    status_reg    <= status_next;
                    match_reg     <= match_next;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.match_offset = match_reg;

endmodule

`default_nettype wire

>>> rtl/bmfs_checker.sv
// Port-level checker for the bracket matcher, bound to the top level.
// Depends on bmfs_pkg and bracket_match_forward_scan.
`timescale 1ns / 1ps
`default_nettype none

module bmfs_checker
    import bmfs_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire status_t out_status,
    input wire offset_t out_offset
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_offset))
        else $error("result payload changed while stalled");

    // only a match carries an offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STATUS_MATCH |-> out_offset == '0)
        else $error("nonzero offset on a non-match result");

    // a fresh result follows an earlier character transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding character transfer");

endmodule

bind bracket_match_forward_scan bmfs_checker u_bmfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (text.valid),
    .in_ready   (text.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status),
    .out_offset (result.match_offset)
);

`default_nettype wire
